// ===== rtl/itoa_pkg.sv =====
// Shared constants, state encoding and control/status structs for the
// signed integer to decimal ASCII converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 6;
	localparam int NDIG       = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCD_W      = NDIG * 4;
	localparam int CNT_W      = $clog2(DATA_WIDTH);
	localparam int LEFT_W     = $clog2(NDIG + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);
	localparam logic [CHAR_W-1:0] ASCII_NINE  = CHAR_W'(57);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift_bit;
		logic shift_digit;
		logic sel_minus;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic top_zero;
		logic last_digit;
		logic neg;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/itoa_dp.sv =====
// Datapath: magnitude register, shift-and-add-3 BCD converter and
// character output mux. Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_dp (
	input  wire                                 clk,
	input  wire logic signed [itoa_pkg::VALUE_W-1:0] value,
	input  wire itoa_pkg::cmd_t                 cmd,
	output itoa_pkg::sts_t                      sts,
	output logic [itoa_pkg::CHAR_W-1:0]         ascii_char,
	output logic                                is_last
);

	logic [itoa_pkg::DATA_WIDTH-1:0] raw;
	logic [itoa_pkg::DATA_WIDTH-1:0] mag_q;
	logic [itoa_pkg::BCD_W-1:0]      bcd_q;
	logic [itoa_pkg::BCD_W-1:0]      bcd_adj;
	logic [itoa_pkg::CNT_W-1:0]      bitcnt_q;
	logic [itoa_pkg::LEFT_W-1:0]     left_q;
	logic                            neg_q;
	logic [3:0]                      top_digit;

	assign raw = itoa_pkg::DATA_WIDTH'(value);

	always_comb begin
		for (int i = 0; i < itoa_pkg::NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q    <= raw[itoa_pkg::DATA_WIDTH-1];
			mag_q    <= raw[itoa_pkg::DATA_WIDTH-1] ? (~raw + 1'b1) : raw;
			bcd_q    <= '0;
			bitcnt_q <= '0;
			left_q   <= itoa_pkg::LEFT_W'(itoa_pkg::NDIG);
		end else if (cmd.shift_bit) begin
			bcd_q    <= {bcd_adj[itoa_pkg::BCD_W-2:0], mag_q[itoa_pkg::DATA_WIDTH-1]};
			mag_q    <= {mag_q[itoa_pkg::DATA_WIDTH-2:0], 1'b0};
			bitcnt_q <= bitcnt_q + 1'b1;
		end else if (cmd.shift_digit) begin
			bcd_q  <= {bcd_q[itoa_pkg::BCD_W-5:0], 4'd0};
			left_q <= left_q - 1'b1;
		end
	end

	assign top_digit = bcd_q[itoa_pkg::BCD_W-1 -: 4];

	always_comb begin
		sts.conv_done  = (bitcnt_q == itoa_pkg::CNT_W'(itoa_pkg::DATA_WIDTH - 1));
		sts.top_zero   = (top_digit == 4'd0);
		sts.last_digit = (left_q == itoa_pkg::LEFT_W'(1));
		sts.neg        = neg_q;
	end

	assign ascii_char = cmd.sel_minus ? itoa_pkg::ASCII_MINUS
	                                  : itoa_pkg::ASCII_ZERO + {2'b00, top_digit};
	assign is_last    = !cmd.sel_minus && sts.last_digit;

endmodule

`default_nettype wire

// ===== rtl/itoa_ctrl.sv =====
// Controller: sequences load, bit-serial conversion, leading-zero skip
// and character emission. Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 value_valid,
	output logic                value_stall,
	output logic                char_valid,
	input  wire                 char_stall,
	input  wire itoa_pkg::sts_t sts,
	output itoa_pkg::cmd_t      cmd
);

	itoa_pkg::state_t state_q;
	itoa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (value_valid) state_d = itoa_pkg::ST_CONV;
			end
			itoa_pkg::ST_CONV: begin
				if (sts.conv_done) state_d = itoa_pkg::ST_SKIP;
			end
			itoa_pkg::ST_SKIP: begin
				if (!sts.top_zero || sts.last_digit) begin
					state_d = sts.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGIT;
				end
			end
			itoa_pkg::ST_SIGN: begin
				if (!char_stall) state_d = itoa_pkg::ST_DIGIT;
			end
			itoa_pkg::ST_DIGIT: begin
				if (!char_stall && sts.last_digit) state_d = itoa_pkg::ST_IDLE;
			end
			default: state_d = itoa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		value_stall     = (state_q != itoa_pkg::ST_IDLE);
		char_valid      = (state_q == itoa_pkg::ST_SIGN) || (state_q == itoa_pkg::ST_DIGIT);
		cmd.load        = (state_q == itoa_pkg::ST_IDLE) && value_valid;
		cmd.shift_bit   = (state_q == itoa_pkg::ST_CONV);
		cmd.shift_digit = ((state_q == itoa_pkg::ST_SKIP) && sts.top_zero && !sts.last_digit)
		                || ((state_q == itoa_pkg::ST_DIGIT) && !char_stall);
		cmd.sel_minus   = (state_q == itoa_pkg::ST_SIGN);
	end

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level: signed integer to decimal ASCII text converter.
// Instantiates itoa_ctrl and itoa_dp; depends on itoa_pkg.
//
// Usage:
//   Input channel value_valid/value_stall carries one signed 32-bit value
//   per beat. Output channel char_valid/char_stall carries one ASCII
//   character per beat, most significant first, with is_last set on the
//   final character. Negative values start with '-'; zero gives '0'.
//   One item is converted at a time. After the accepting cycle the
//   shift-and-add-3 converter takes one magnitude bit per cycle until
//   all DATA_WIDTH bits are in, then suppresses leading zeros one digit
//   at a time until the first nonzero or final digit, then emits one
//   character per beat, the sign first for a negative value.
//   value_stall is high from the accepting edge until the last character
//   beat is taken. While char_stall is high the current character and
//   is_last hold. Reset returns the controller to idle and drops any
//   conversion in progress; no characters are pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      value_valid,
	output logic                                     value_stall,
	input  wire logic signed [itoa_pkg::VALUE_W-1:0] value,
	output logic                                     char_valid,
	input  wire                                      char_stall,
	output logic [itoa_pkg::CHAR_W-1:0]              ascii_char,
	output logic                                     is_last
);

	itoa_pkg::cmd_t cmd;
	itoa_pkg::sts_t sts;

	itoa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	itoa_dp u_dp (
		.clk        (clk),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.ascii_char (ascii_char),
		.is_last    (is_last)
	);

endmodule

`default_nettype wire

// ===== rtl/itoa_chk.sv =====
// Port-level checker for signed_int_to_decimal_ascii, bound to the top.
// Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_chk (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              value_valid,
	input wire                              value_stall,
	input wire                              char_valid,
	input wire                              char_stall,
	input wire [itoa_pkg::CHAR_W-1:0]       ascii_char,
	input wire                              is_last
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(ascii_char) && $stable(is_last))
		else $error("stalled character beat changed");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (ascii_char == itoa_pkg::ASCII_MINUS)
		|| ((ascii_char >= itoa_pkg::ASCII_ZERO) && (ascii_char <= itoa_pkg::ASCII_NINE)))
		else $error("character out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && !value_stall |=> value_stall)
		else $error("input taken again before conversion finished");

	a_minus_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && (ascii_char == itoa_pkg::ASCII_MINUS)
		|=> char_valid && (ascii_char != itoa_pkg::ASCII_MINUS) && !is_last ||
		    char_valid && (ascii_char != itoa_pkg::ASCII_MINUS))
		else $error("sign not followed by a digit");

	a_out_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> value_stall)
		else $error("character beat while input side idle");

endmodule

bind signed_int_to_decimal_ascii itoa_chk u_itoa_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.value_valid (value_valid),
	.value_stall (value_stall),
	.char_valid  (char_valid),
	.char_stall  (char_stall),
	.ascii_char  (ascii_char),
	.is_last     (is_last)
);

`default_nettype wire

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
// Testbench for signed_int_to_decimal_ascii: drives signed values, predicts
// the decimal ASCII text of each and checks every character beat in order.
// Depends on itoa_pkg and the signed_int_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

	localparam int PHASE_LEN  = 110;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_WAIT  = 100;

	typedef struct {
		logic                         drain;
		logic [itoa_pkg::VALUE_W-1:0] num;
	} value_slot_t;

	typedef struct {
		logic [itoa_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} text_beat_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                value_valid = 1'b0;
	logic                                value_stall;
	logic signed [itoa_pkg::VALUE_W-1:0] value = '0;
	logic                                char_valid;
	logic                                char_stall = 1'b0;
	logic [itoa_pkg::CHAR_W-1:0]         ascii_char;
	logic                                is_last;

	value_slot_t pending_values[$];
	text_beat_t  expected_text[$];
	int          values_taken = 0;
	int          quiet_cycles = 0;
	bit          failed = 1'b0;

	signed_int_to_decimal_ascii dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.value      (value),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.ascii_char (ascii_char),
		.is_last    (is_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int send_idle_pct(int taken);
		return (taken < PHASE_LEN) ? 11 : (taken < 2 * PHASE_LEN) ? 53 : 0;
	endfunction

	function automatic int recv_idle_pct(int taken);
		return (taken < PHASE_LEN) ? 53 : (taken < 2 * PHASE_LEN) ? 11 : 0;
	endfunction

	// Append the decimal text of one value, sign first, to the expected stream.
	function automatic void push_decimal_text(logic [itoa_pkg::VALUE_W-1:0] num);
		logic                       negative;
		bit [itoa_pkg::VALUE_W-1:0] mag;
		logic [3:0]                 digits[12];
		int                         ndig;
		int                         total;
		int                         pos;
		text_beat_t                 beat;
		negative = num[itoa_pkg::VALUE_W-1];
		mag = negative ? (~num + 1'b1) : num;
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % 10);
			mag = mag / 10;
			ndig++;
		end while (mag != 0);
		total = ndig + (negative ? 1 : 0);
		pos = 0;
		if (negative) begin
			beat.ch = itoa_pkg::ASCII_MINUS;
			beat.last = (total == 1);
			expected_text.push_back(beat);
			pos++;
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			beat.ch = itoa_pkg::ASCII_ZERO + itoa_pkg::CHAR_W'(digits[k]);
			beat.last = (pos == total - 1);
			expected_text.push_back(beat);
			pos++;
		end
	endfunction

	function automatic void queue_value(logic [itoa_pkg::VALUE_W-1:0] num);
		value_slot_t s;
		s.drain = 1'b0;
		s.num = num;
		pending_values.push_back(s);
	endfunction

	function automatic void queue_drain();
		value_slot_t s;
		s.drain = 1'b1;
		s.num = '0;
		pending_values.push_back(s);
	endfunction

	// Input driver: hold while stalled, advance on a taken beat.
	always @(posedge clk or negedge arst_n) begin : value_driver
		value_slot_t s;
		if (!arst_n) begin
			value_valid <= 1'b0;
			value <= '0;
		end else begin
			if (value_valid && !value_stall) begin
				push_decimal_text(value);
				values_taken++;
			end
			if (!value_valid || !value_stall) begin
				if (pending_values.size() > 0 && pending_values[0].drain) begin
					if (expected_text.size() == 0)
						void'(pending_values.pop_front());
					value_valid <= 1'b0;
				end else if (pending_values.size() > 0 &&
					     $urandom_range(99) >= send_idle_pct(values_taken)) begin
					s = pending_values.pop_front();
					value <= s.num;
					value_valid <= 1'b1;
				end else begin
					value_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			char_stall <= 1'b0;
		else
			char_stall <= ($urandom_range(99) < recv_idle_pct(values_taken));
	end

	// Output monitor: compare each taken character beat with the oldest expectation.
	always @(posedge clk) begin : text_monitor
		text_beat_t exp_beat;
		if (arst_n && char_valid && !char_stall) begin
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual char %0d last %0b",
					 $time, ascii_char, is_last);
				failed = 1'b1;
			end else begin
				exp_beat = expected_text.pop_front();
				if (ascii_char !== exp_beat.ch) begin
					$display("%0t: ascii_char mismatch: expected %0d, actual %0d",
						 $time, exp_beat.ch, ascii_char);
					failed = 1'b1;
				end
				if (is_last !== exp_beat.last) begin
					$display("%0t: is_last mismatch: expected %0b, actual %0b",
						 $time, exp_beat.last, is_last);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((value_valid && !value_stall) || (char_valid && !char_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [itoa_pkg::VALUE_W-1:0] num;
		bit [itoa_pkg::VALUE_W-1:0]   pow;
		int                           k;
		queue_value(32'd0);
		queue_value(32'd1);
		queue_value(-32'sd1);
		queue_value(32'd9);
		queue_value(32'd10);
		queue_value(-32'sd10);
		queue_value(32'd99);
		queue_value(32'd100);
		queue_value(32'h7FFF_FFFF);
		queue_value(32'h8000_0000);
		queue_value(32'h8000_0001);
		queue_value(32'd1000000000);
		queue_value(32'd999999999);
		queue_value(-32'sd999999999);
		queue_value(32'd1234567890);
		queue_value(-32'sd1234567890);
		queue_value(32'h5555_5555);
		queue_value(32'hAAAA_AAAA);
		queue_value(-32'sd5);
		queue_drain();
		for (int i = 0; i < 312; i++) begin
			if (i == 100 || i == 200)
				queue_drain();
			case ($urandom_range(3))
			0: num = $urandom;
			1: num = $urandom_range(0, 99);
			2: begin
				k = $urandom_range(1, 9);
				pow = 1;
				repeat (k) pow = pow * 10;
				num = pow + $urandom_range(0, 2) - 1;
			end
			default: begin
				k = $urandom_range(1, 9);
				pow = 1;
				repeat (k) pow = pow * 10;
				num = $urandom % pow;
			end
			endcase
			if ($urandom_range(1))
				num = -num;
			queue_value(num);
		end
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending_values.size() != 0 || value_valid || expected_text.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (expected_text.size() != 0)
			failed = 1'b1;
		if (!failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
